/* hdl/fdmf_pkg.sv */
// shared types and constants of the frame difference motion filter
`default_nettype none

package fdmf_pkg;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 11;

    localparam logic [CFG_IW-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IW-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [9:0]  THRESHOLD_RESET = 10'd100;
    localparam logic [10:0] WIDTH_RESET     = 11'd640;
    localparam logic [9:0]  HEIGHT_RESET    = 10'd480;

    localparam int Q_DEPTH = 2;

    // one point as classified by the front part
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
        logic        primed;
        logic        coord_ok;
        logic [9:0]  threshold;
    } t_point;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic full;
        logic avail;
        logic pop;
    } t_qctl;

endpackage

`default_nettype wire

/* hdl/fdmf_if.sv */
// stream interfaces for points in and filtered results out
`default_nettype none

interface fdmf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    modport source (output valid, pos_x, pos_y, pos_z, red, green, blue, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, red, green, blue, output ready);
endinterface

interface fdmf_out_if;
    logic        valid;
    logic        ready;
    logic        kept;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        frame_last;

    modport source (output valid, kept, out_x, out_y, out_z, out_red, out_green, out_blue,
                    frame_last, input ready);
    modport sink (input valid, kept, out_x, out_y, out_z, out_red, out_green, out_blue,
                  frame_last, output ready);
endinterface

`default_nettype wire

/* hdl/fdmf_front.sv */
// front part: config registers, scan position, point classification
`default_nettype none

module fdmf_front import fdmf_pkg::*; #(
    parameter int MAX_PIXELS = 524288
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    fdmf_in_if.sink           i_pt,
    input  logic              i_full,
    output logic              o_push,
    output t_point            o_point,
    output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] o_addr
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = (AW + 1 > 21) ? AW + 1 : 21;
    localparam int RST_PROD = int'(WIDTH_RESET) * int'(HEIGHT_RESET);
    localparam int RST_TOTAL = (RST_PROD > MAX_PIXELS) ? MAX_PIXELS : RST_PROD;
    localparam logic [AW-1:0] RST_LAST = AW'(RST_TOTAL - 1);

    logic [9:0]    r_threshold;
    logic [10:0]   r_width;
    logic [9:0]    r_height;
    logic [AW-1:0] r_last_idx, n_last_idx;
    logic [AW-1:0] r_index, n_index;
    logic          r_primed, n_primed;

    logic          accept;
    logic          last;
    logic          size_wr;
    logic [10:0]   sel_w;
    logic [9:0]    sel_h;
    logic [20:0]   prod;
    logic [CW-1:0] total;

    assign i_pt.ready = !i_full;
    assign accept     = i_pt.valid && !i_full;
    assign last       = (r_index == r_last_idx);
    assign size_wr    = i_cfg_we && ((i_cfg_idx == REG_WIDTH) || (i_cfg_idx == REG_HEIGHT));

    // frame length from the size that holds after this write
    always_comb begin
        sel_w = (i_cfg_we && i_cfg_idx == REG_WIDTH) ? i_cfg_data : r_width;
        sel_h = (i_cfg_we && i_cfg_idx == REG_HEIGHT) ? i_cfg_data[9:0] : r_height;
        if (sel_w == 11'd0) sel_w = 11'd1;
        if (sel_h == 10'd0) sel_h = 10'd1;
        prod  = 21'(sel_w) * 21'(sel_h);
        total = (CW'(prod) > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : CW'(prod);
        n_last_idx = size_wr ? AW'(total - CW'(1)) : r_last_idx;
    end

    always_comb begin
        n_index  = r_index;
        n_primed = r_primed;
        if (accept) begin
            if (last) begin
                n_index  = '0;
                n_primed = 1'b1;
            end else begin
                n_index = r_index + AW'(1);
            end
        end
        if (size_wr) begin
            n_index  = '0;
            n_primed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_last_idx  <= RST_LAST;
            r_index     <= '0;
            r_primed    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_THRESHOLD: r_threshold <= i_cfg_data[9:0];
                    REG_WIDTH:     r_width     <= i_cfg_data;
                    REG_HEIGHT:    r_height    <= i_cfg_data[9:0];
                    default:       ;
                endcase
            end
            r_last_idx <= n_last_idx;
            r_index    <= n_index;
            r_primed   <= n_primed;
        end
    end

    always_comb begin
        o_point.pos_x     = i_pt.pos_x;
        o_point.pos_y     = i_pt.pos_y;
        o_point.pos_z     = i_pt.pos_z;
        o_point.red       = i_pt.red;
        o_point.green     = i_pt.green;
        o_point.blue      = i_pt.blue;
        o_point.last      = last;
        o_point.primed    = r_primed;
        // inf or nan in any coordinate disqualifies the point
        o_point.coord_ok  = (i_pt.pos_x[30:23] != 8'hFF) && (i_pt.pos_y[30:23] != 8'hFF)
                         && (i_pt.pos_z[30:23] != 8'hFF);
        o_point.threshold = r_threshold;
    end

    assign o_push = accept;
    assign o_addr = r_index;

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= r_last_idx)
        else $error("scan position beyond frame end");

    a_primed_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last && !size_wr) |=> (r_primed && r_index == '0))
        else $error("frame end did not prime and wrap");

endmodule

`default_nettype wire

/* hdl/fdmf_queue.sv */
// short queue between the front and back parts
`default_nettype none

module fdmf_queue import fdmf_pkg::*; #(
    parameter int AW = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_point        i_point,
    input  logic [AW-1:0] i_addr,
    output t_point        o_point,
    output logic [AW-1:0] o_addr,
    input  t_qctl         i_ctl,
    output t_qctl         o_ctl
);

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_point        r_pt   [Q_DEPTH];
    logic [AW-1:0] r_addr [Q_DEPTH];
    logic [QPW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_count;

    logic push, pop;

    assign push = i_ctl.push && (r_count != QCW'(Q_DEPTH));
    assign pop  = i_ctl.pop && (r_count != '0);

    function automatic logic [QPW-1:0] ptr_inc(input logic [QPW-1:0] p);
        return (p == QPW'(Q_DEPTH - 1)) ? '0 : p + QPW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_pt[r_wp]   <= i_point;
            r_addr[r_wp] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wp <= ptr_inc(r_wp);
            if (pop)  r_rp <= ptr_inc(r_rp);
            if (push && !pop) r_count <= r_count + QCW'(1);
            else if (pop && !push) r_count <= r_count - QCW'(1);
        end
    end

    assign o_point   = r_pt[r_rp];
    assign o_addr    = r_addr[r_rp];
    assign o_ctl.push  = push;
    assign o_ctl.pop   = pop;
    assign o_ctl.full  = (r_count == QCW'(Q_DEPTH));
    assign o_ctl.avail = (r_count != '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(Q_DEPTH))
        else $error("queue overfilled");

endmodule

`default_nettype wire

/* hdl/fdmf_back.sv */
// back part: colour store, absolute difference sum, threshold, output register
`default_nettype none

module fdmf_back import fdmf_pkg::*; #(
    parameter int MAX_PIXELS = 524288
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_avail,
    output logic   o_pop,
    input  t_point i_point,
    input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] i_addr,
    fdmf_out_if.source o_res
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [23:0]   mem [MAX_PIXELS];

    logic          r_s1_valid;
    t_point        r_s1_pt;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_fwd;
    logic [23:0]   r_fwd_color;
    logic [23:0]   r_rdata;
    logic          r_out_valid;

    logic          out_free, s1_move, pop;
    logic [23:0]   s1_color, old_color;
    logic [7:0]    d_r, d_g, d_b;
    logic [9:0]    change;
    logic          kept;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    assign out_free = !r_out_valid || o_res.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign pop      = i_avail && (!r_s1_valid || s1_move);
    assign o_pop    = pop;

    assign s1_color  = {r_s1_pt.red, r_s1_pt.green, r_s1_pt.blue};
    // the previous point's write lands on the same edge as this read
    assign old_color = r_s1_fwd ? r_fwd_color : r_rdata;

    always_comb begin
        d_r    = abs_diff(r_s1_pt.red,   old_color[23:16]);
        d_g    = abs_diff(r_s1_pt.green, old_color[15:8]);
        d_b    = abs_diff(r_s1_pt.blue,  old_color[7:0]);
        change = 10'(d_r) + 10'(d_g) + 10'(d_b);
        kept   = r_s1_pt.primed && r_s1_pt.coord_ok && (change >= r_s1_pt.threshold);
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) mem[r_s1_addr] <= s1_color;
        if (pop)     r_rdata <= mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_pt     <= i_point;
            r_s1_addr   <= i_addr;
            r_s1_fwd    <= s1_move && (r_s1_addr == i_addr);
            r_fwd_color <= s1_color;
        end
        if (s1_move) begin
            o_res.kept       <= kept;
            o_res.out_x      <= r_s1_pt.pos_x;
            o_res.out_y      <= r_s1_pt.pos_y;
            o_res.out_z      <= r_s1_pt.pos_z;
            o_res.out_red    <= r_s1_pt.red;
            o_res.out_green  <= r_s1_pt.green;
            o_res.out_blue   <= r_s1_pt.blue;
            o_res.frame_last <= r_s1_pt.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) r_s1_valid <= 1'b1;
            else if (s1_move) r_s1_valid <= 1'b0;
            if (s1_move) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid = r_out_valid;

    a_pop_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_s1_valid)
        else $error("popped beat lost before stage one");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(pop) && r_s1_fwd |-> $past(s1_move))
        else $error("forwarded colour without a store write");

endmodule

`default_nettype wire

/* hdl/frame_difference_motion_filter_top.sv */
// frame difference motion filter: top level
// a point beat passes through the queue, then stage one with its colour store read, then the output register
// throughput: one point per cycle while the output is not stalled, set by one colour store read and one write per point
// a stalled output fills the two-entry queue before input ready drops
// reset (synchronous, active low) clears control, config and scan position
// the colour store is not cleared: the first frame after reset or a size write only fills it
`default_nettype none

module frame_difference_motion_filter_top import fdmf_pkg::*; #(
    parameter int MAX_PIXELS = 524288
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    fdmf_in_if.sink           i_pt,
    fdmf_out_if.source        o_res
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    t_point        f_point, q_point;
    logic [AW-1:0] f_addr, q_addr;
    logic          f_push, b_pop;
    t_qctl         q_ctl_in, q_ctl_out;

    assign q_ctl_in.push  = f_push;
    assign q_ctl_in.pop   = b_pop;
    assign q_ctl_in.full  = 1'b0;
    assign q_ctl_in.avail = 1'b0;

    fdmf_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (i_pt),
        .i_full     (q_ctl_out.full),
        .o_push     (f_push),
        .o_point    (f_point),
        .o_addr     (f_addr)
    );

    fdmf_queue #(.AW(AW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (f_point),
        .i_addr  (f_addr),
        .o_point (q_point),
        .o_addr  (q_addr),
        .i_ctl   (q_ctl_in),
        .o_ctl   (q_ctl_out)
    );

    fdmf_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_ctl_out.avail),
        .o_pop   (b_pop),
        .i_point (q_point),
        .i_addr  (q_addr),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
